// File: sv/cta_pkg.sv
// ============================================================================
// cta_pkg: shared types and constants for the cosine approximation block
// Fixed-point formats, range-reduction constants and the queue item type.
// ============================================================================
`default_nettype none

package cta_pkg;

  // Fixed-point formats of the ports and of the internal datapaths.
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 30;
  localparam int RED_FRAC        = 32;
  localparam int SER_FRAC        = 30;

  // Range-reduction constants with 32 fraction bits, rounded to nearest.
  localparam longint Q32_HALF_PI = 64'sd6746518852;
  localparam longint Q32_PI      = 64'sd13493037705;
  localparam longint Q32_TWO_PI  = 64'sd26986075409;

  // Reciprocal of 2*pi used to estimate the quotient from the top bits.
  localparam int     RECIP_SHIFT = 20;
  localparam int     RECIP_W     = 19;
  localparam longint Q_RECIP     =
    ((64'sd1 <<< (RED_FRAC + RECIP_SHIFT)) + Q32_TWO_PI / 2) / Q32_TWO_PI;

  // Reduction datapath widths.
  localparam int ANGLE_SHIFT = RED_FRAC - ANGLE_FRAC_BITS;
  localparam int VW          = 32 + ANGLE_SHIFT + 2;
  localparam int TW          = VW - RED_FRAC;
  localparam int PW          = TW + RECIP_W;
  localparam int QW          = PW - RECIP_SHIFT;
  localparam int R0W         = 37;
  localparam int RW          = 35;
  localparam int R1W         = 34;
  localparam int XW          = 31;

  // Exact division of 31-bit values by 3 and by 15 through reciprocals.
  localparam int     DIV3_SHIFT  = 33;
  localparam int     DIV15_SHIFT = 35;
  localparam longint DIV3_MUL    = ((64'sd1 <<< DIV3_SHIFT) + 2) / 3;
  localparam longint DIV15_MUL   = ((64'sd1 <<< DIV15_SHIFT) + 14) / 15;

  // Depth of the queue between the reduction front and the series back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One reduced item handed from the front to the back.
  typedef struct packed {
    logic [XW-1:0] x;
    logic          flip;
  } cta_item_t;

endpackage

`default_nettype wire

// File: sv/cta_front.sv
// ============================================================================
// cta_front: range reduction of the input angle
// Shifts the angle by pi/2, reduces it modulo 2*pi, folds it into [0, pi/2]
// and records whether the result's sign must be flipped.
// ============================================================================
`default_nettype none

module cta_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic signed [31:0]  angle,
  output logic                     full,
  output logic                     q_push,
  output cta_pkg::cta_item_t       q_item,
  input  wire logic                q_full
);

  logic [5:0] vld;
  logic       en;

  logic signed [cta_pkg::VW-1:0]  v1, v2;
  logic signed [cta_pkg::QW-1:0]  q2;
  logic signed [cta_pkg::R0W-1:0] r0_3;
  logic [cta_pkg::RW-1:0]         r4;
  logic [cta_pkg::R1W-1:0]        r1_5;
  logic                           flip5, flip6;
  logic [cta_pkg::XW-1:0]         x6;

  logic signed [cta_pkg::VW-1:0]  v_next;
  logic signed [cta_pkg::TW-1:0]  t1;
  logic signed [cta_pkg::PW-1:0]  est_prod;
  logic signed [cta_pkg::VW-1:0]  r0_full;
  logic signed [cta_pkg::R0W-1:0] r_fix;
  logic                           flip_next;
  logic [cta_pkg::R1W-1:0]        r1_next;
  logic [cta_pkg::R1W-1:0]        r2;

  // The pipeline moves as a whole unless its last item waits on the queue.
  assign en     = !vld[5] || !q_full;
  assign full   = !en;
  assign q_push = vld[5] && !q_full;
  assign q_item = '{x: x6, flip: flip6};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], push};
    end
  end

  // Scale to 32 fraction bits and add pi/2.
  assign v_next = (cta_pkg::VW'(angle) <<< cta_pkg::ANGLE_SHIFT)
                + cta_pkg::VW'(cta_pkg::Q32_HALF_PI);

  // Quotient estimate from the integer part; it is off by at most one.
  assign t1       = v1[cta_pkg::VW-1:cta_pkg::RED_FRAC];
  assign est_prod = cta_pkg::PW'(t1) * cta_pkg::PW'(cta_pkg::Q_RECIP);

  // Remainder against the estimate, in (-2*pi, 4*pi).
  assign r0_full = v2 - cta_pkg::VW'(q2) * cta_pkg::VW'(cta_pkg::Q32_TWO_PI);

  // One correction step brings the remainder into [0, 2*pi).
  always_comb begin
    if (r0_3 < 0) begin
      r_fix = r0_3 + cta_pkg::R0W'(cta_pkg::Q32_TWO_PI);
    end else if (r0_3 >= cta_pkg::R0W'(cta_pkg::Q32_TWO_PI)) begin
      r_fix = r0_3 - cta_pkg::R0W'(cta_pkg::Q32_TWO_PI);
    end else begin
      r_fix = r0_3;
    end
  end

  // The lower half-turn is kept; the upper one is moved down with a flipped sign.
  always_comb begin
    flip_next = (r4 >= cta_pkg::RW'(cta_pkg::Q32_PI));
    if (flip_next) begin
      r1_next = cta_pkg::R1W'(r4 - cta_pkg::RW'(cta_pkg::Q32_PI));
    end else begin
      r1_next = r4[cta_pkg::R1W-1:0];
    end
  end

  // Values above pi/2 are mirrored to pi minus themselves.
  always_comb begin
    if (r1_5 > cta_pkg::R1W'(cta_pkg::Q32_HALF_PI)) begin
      r2 = cta_pkg::R1W'(cta_pkg::Q32_PI) - r1_5;
    end else begin
      r2 = r1_5;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      v1    <= v_next;
      v2    <= v1;
      q2    <= est_prod[cta_pkg::PW-1:cta_pkg::RECIP_SHIFT];
      r0_3  <= r0_full[cta_pkg::R0W-1:0];
      r4    <= r_fix[cta_pkg::RW-1:0];
      r1_5  <= r1_next;
      flip5 <= flip_next;
      x6    <= r2[cta_pkg::XW+1:2];
      flip6 <= flip5;
    end
  end

endmodule

`default_nettype wire

// File: sv/cta_queue.sv
// ============================================================================
// cta_queue: short queue between the reduction front and the series back
// Holds reduced items so that each side can stall on its own.
// ============================================================================
`default_nettype none

module cta_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  cta_pkg::cta_item_t       item_in,
  output logic                     full,
  input  wire logic                pop,
  output cta_pkg::cta_item_t       item_out,
  output logic                     empty
);

  cta_pkg::cta_item_t mem [cta_pkg::QDEPTH];
  logic [cta_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [cta_pkg::QAW:0]   cnt;
  logic                    do_push, do_pop;

  assign full     = (cnt == (cta_pkg::QAW+1)'(cta_pkg::QDEPTH));
  assign empty    = (cnt == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/cta_back.sv
// ============================================================================
// cta_back: fifth-order sine series and result buffer
// Evaluates x - x^3/6 + x^5/120 on the reduced value, applies the sign and
// holds finished results in a two-entry output queue.
// ============================================================================
`default_nettype none

module cta_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  cta_pkg::cta_item_t       q_item,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic signed [31:0]       cosine
);

  logic [3:0] vld;
  logic       en;

  logic [cta_pkg::XW-1:0] x1, x2, x3, x4;
  logic                   f1, f2, f3, f4;
  logic [31:0]            sq1, sq2, cu2;
  logic [33:0]            p5;
  logic [29:0]            d6_3, d6_4;
  logic [27:0]            d120;

  logic [61:0] sq_prod;
  logic [62:0] cu_prod;
  logic [63:0] p5_prod;
  logic [62:0] d6_prod;
  logic [62:0] d120_prod;
  logic [31:0] sum;
  logic [31:0] scaled;
  logic signed [31:0] res;

  logic signed [31:0] omem [2];
  logic       o_wr_ptr, o_rd_ptr;
  logic [1:0] o_cnt;
  logic       o_full, o_wr, o_rd;

  // The series pipeline moves unless its last item waits on the output queue.
  assign en    = !vld[3] || !o_full;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], !q_empty};
    end
  end

  // Powers of x, each truncated back to 30 fraction bits.
  assign sq_prod = 62'(q_item.x) * 62'(q_item.x);
  assign cu_prod = 63'(sq1) * 63'(x1);
  assign p5_prod = 64'(cu2) * 64'(sq2);

  // x^3/6 as (x^3/2)/3 and x^5/120 as (x^5/8)/15, both exact.
  assign d6_prod   = 63'(cu2[31:1]) * 63'(cta_pkg::DIV3_MUL);
  assign d120_prod = 63'(p5[33:3]) * 63'(cta_pkg::DIV15_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= q_item.x;
      f1   <= q_item.flip;
      sq1  <= sq_prod[61:30];
      x2   <= x1;
      f2   <= f1;
      sq2  <= sq1;
      cu2  <= cu_prod[61:30];
      x3   <= x2;
      f3   <= f2;
      p5   <= p5_prod[63:30];
      d6_3 <= d6_prod[62:cta_pkg::DIV3_SHIFT];
      x4   <= x3;
      f4   <= f3;
      d6_4 <= d6_3;
      d120 <= d120_prod[62:cta_pkg::DIV15_SHIFT];
    end
  end

  // Sum of the series, output scaling and sign.
  assign sum    = 32'(x4) - 32'(d6_4) + 32'(d120);
  assign scaled = sum >> (cta_pkg::SER_FRAC - cta_pkg::OUT_FRAC_BITS);
  assign res    = f4 ? -$signed(scaled) : $signed(scaled);

  // Two-entry output queue.
  assign o_full = (o_cnt == 2'd2);
  assign empty  = (o_cnt == 2'd0);
  assign o_wr   = en && vld[3];
  assign o_rd   = pop && !empty;
  assign cosine = omem[o_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr_ptr <= 1'b0;
      o_rd_ptr <= 1'b0;
      o_cnt    <= 2'd0;
    end else begin
      if (o_wr) begin
        o_wr_ptr <= !o_wr_ptr;
      end
      if (o_rd) begin
        o_rd_ptr <= !o_rd_ptr;
      end
      if (o_wr && !o_rd) begin
        o_cnt <= o_cnt + 2'd1;
      end else if (o_rd && !o_wr) begin
        o_cnt <= o_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_wr) begin
      omem[o_wr_ptr] <= res;
    end
  end

endmodule

`default_nettype wire

// File: sv/cosine_taylor_approx.sv
// ============================================================================
// cosine_taylor_approx: fixed-point cosine by range reduction and series
// Computes cos(angle) for a Q8.24 angle as a Q2.30 result.
// ============================================================================
// The block takes one angle per clock while it is not full and returns one
// cosine per angle, in order. An accepted angle passes through six stages of
// range reduction (scaling with the quarter-turn shift, quotient estimate,
// remainder, correction, half-turn fold, quarter-turn mirror), is written into
// the middle queue, passes through four stages of multipliers for the series
// and is written into the output queue, where it can be taken. The throughput
// of one item per cycle, while the output side does not stall, is set by the
// reduction and series pipelines, which each hold one item per stage; a
// four-entry queue between them and a two-entry output queue absorb stalls.
`default_nettype none

module cosine_taylor_approx (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [31:0]  angle,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       cosine
);

  cta_pkg::cta_item_t front_item, back_item;
  logic               mq_push, mq_full, mq_pop, mq_empty;

  // Range reduction.
  cta_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .angle  (angle),
    .full   (full),
    .q_push (mq_push),
    .q_item (front_item),
    .q_full (mq_full)
  );

  // Queue between reduction and series.
  cta_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mq_push),
    .item_in  (front_item),
    .full     (mq_full),
    .pop      (mq_pop),
    .item_out (back_item),
    .empty    (mq_empty)
  );

  // Series evaluation and result buffer.
  cta_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mq_empty),
    .q_item  (back_item),
    .q_pop   (mq_pop),
    .pop     (pop),
    .empty   (empty),
    .cosine  (cosine)
  );

endmodule

`default_nettype wire

// File: sv/cta_checker.sv
// ============================================================================
// cta_checker: port-level checks for the cosine approximation block
// Watches reset behavior, known accepted angles, result holding and the range of results.
// ============================================================================
`default_nettype none

module cta_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               push,
  input wire logic               full,
  input wire logic signed [31:0] angle,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [31:0] cosine
);

  localparam logic signed [31:0] LIM =
    32'((64'sd1 <<< cta_pkg::OUT_FRAC_BITS)
      + (64'sd1 <<< (cta_pkg::OUT_FRAC_BITS - 7)));

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  // An accepted angle is always a known value.
  a_angle_known: assert property (@(posedge clk) disable iff (rst)
    push && !full |-> !$isunknown(angle))
    else $error("unknown angle accepted");

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(cosine))
    else $error("waiting result changed or vanished");

  // A cosine never leaves about one in magnitude.
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (cosine <= LIM) && (cosine >= -LIM))
    else $error("cosine out of range");

endmodule

bind cosine_taylor_approx cta_checker u_cta_checker (.*);

`default_nettype wire

// File: test/tb_cosine_taylor_approx.sv
// ============================================================================
// tb_cosine_taylor_approx: self-checking testbench for the cosine block
// Streams Q8.24 angles into the block and checks each Q2.30 cosine against a
// bit-exact predictor of range reduction and the fifth-order sine series.
// ============================================================================

module tb_cosine_taylor_approx;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 477;

  // Scoreboard: predicts the cosine of every accepted angle and checks the
  // results in order.
  class cosine_scoreboard;
    typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] cosine;
    } cosine_entry_t;

    cosine_entry_t expected_cosines[$];
    int            errors = 0;

    // Bit-exact cosine: shift by a quarter turn, reduce, fold, then series.
    function automatic logic signed [31:0] cosine_of(logic signed [31:0] a);
      longint      v;
      longint      r;
      longint      s;
      bit          flip;
      bit [63:0]   x;
      bit [63:0]   x2;
      bit [63:0]   x3;
      bit [63:0]   x5;
      v = (longint'(a) <<< (cta_pkg::RED_FRAC - cta_pkg::ANGLE_FRAC_BITS))
        + cta_pkg::Q32_HALF_PI;
      r = v % cta_pkg::Q32_TWO_PI;
      if (r < 0) begin
        r += cta_pkg::Q32_TWO_PI;
      end
      flip = (r >= cta_pkg::Q32_PI);
      if (flip) begin
        r -= cta_pkg::Q32_PI;
      end
      if (r > cta_pkg::Q32_HALF_PI) begin
        r = cta_pkg::Q32_PI - r;
      end
      x  = r;
      x  = x >> (cta_pkg::RED_FRAC - cta_pkg::SER_FRAC);
      x2 = (x * x) >> cta_pkg::SER_FRAC;
      x3 = (x2 * x) >> cta_pkg::SER_FRAC;
      x5 = (x3 * x2) >> cta_pkg::SER_FRAC;
      s  = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120);
      s  = s >>> (cta_pkg::SER_FRAC - cta_pkg::OUT_FRAC_BITS);
      if (flip) begin
        s = -s;
      end
      return s[31:0];
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void note_angle(logic signed [31:0] a);
      cosine_entry_t e;
      e.angle  = a;
      e.cosine = cosine_of(a);
      expected_cosines.push_back(e);
    endfunction

    task check_cosine(logic signed [31:0] got);
      cosine_entry_t e;
      if (expected_cosines.size() == 0) begin
        report($sformatf("cosine %h arrived with no angle waiting", got));
      end else begin
        e = expected_cosines.pop_front();
        if (got !== e.cosine) begin
          report($sformatf("angle %h: cosine %h, expected %h", e.angle, got, e.cosine));
        end
      end
    endtask

    function int pending();
      return expected_cosines.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic signed [31:0] angle;
  logic               empty;
  logic               pop;
  logic signed [31:0] cosine;

  cosine_scoreboard   sb = new();
  int                 phase = 0;
  int                 send_idle_pct = 6;
  int                 recv_idle_pct = 59;
  int                 stall_cycles = 0;

  cosine_taylor_approx dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .angle  (angle),
    .empty  (empty),
    .pop    (pop),
    .cosine (cosine)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor both handshakes at the edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_angle(angle);
      end
      if (pop && !empty) begin
        sb.check_cosine(cosine);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one angle, with random idle cycles ahead of it, and wait until the
  // block takes it.
  task send_angle(input logic signed [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    angle <= a;
    do begin
      @(posedge clk);
    end while (full);
  endtask

  // Random angle: full range, a small range around zero, or close to a
  // multiple of a quarter turn where the folds change.
  function automatic logic signed [31:0] random_angle();
    int  pick;
    int  k;
    real q;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return $urandom;
    end else if (pick < 70) begin
      return $urandom_range(32'h1000_0000) - 32'h0800_0000;
    end
    k = $urandom_range(162) - 81;
    q = k * 1.5707963267948966 * 16777216.0;
    return $rtoi(q) + $urandom_range(128) - 64;
  endfunction

  // Receiver: random pops, with one long hold-off when the last phase begins
  // so that the block fills up and stalls its input.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Main sequence: reset, directed angles, three random phases, drain.
  initial begin
    logic signed [31:0] directed[$];
    int                 drained;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'sd1185911517, 32'sd1185911516, 32'sd1185911518,
                 32'sd26353589, 32'sd26353590, -32'sd26353589, -32'sd26353590,
                 32'sd52707179, -32'sd52707179, 32'sd79060768, 32'sd105414357,
                 32'h00FF_FFFF, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    rst   <= 1'b1;
    push  <= 1'b0;
    angle <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed angles: extremes, the exact half-turn remainder and the folds.
    foreach (directed[i]) begin
      send_angle(directed[i]);
    end

    for (int p = 0; p < 3; p++) begin
      phase = p;
      if (p == 1) begin
        send_idle_pct = 59;
        recv_idle_pct = 6;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_angle(random_angle());
      end
    end
    push <= 1'b0;

    // Drain: wait for every expected cosine, then watch for strays.
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    for (drained = 0; drained < DRAIN_CYCLES; drained++) begin
      @(posedge clk);
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cta_pkg.sv
sv/cta_front.sv
sv/cta_queue.sv
sv/cta_back.sv
sv/cosine_taylor_approx.sv
sv/cta_checker.sv
test/tb_cosine_taylor_approx.sv
